// ===== rtl/tkmh_pkg.sv =====
// ----------------------------------------------------------------------------
// tkmh_pkg
// Shared types and constants for the top-k min-heap with replace-root insert.
// ----------------------------------------------------------------------------
`default_nettype none

package tkmh_pkg;

    // heap geometry
    localparam int HEAP_SIZE = 16;
    localparam int LAST      = HEAP_SIZE - 1;
    localparam int IDX_W     = $clog2(HEAP_SIZE);
    localparam int CNT_W     = $clog2(HEAP_SIZE + 1);

    // field widths
    localparam int POINT_W   = 32;
    localparam int SCORE_W   = 32;
    localparam int ELEM_W    = 5;

    typedef logic [POINT_W-1:0] point_t;
    typedef logic [SCORE_W-1:0] score_t;

    typedef struct packed {
        point_t point;
        score_t score;
    } entry_t;

    // result of one step of the shared compare unit
    typedef struct packed {
        logic pick_right;
        logic swap;
    } cmp_res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SIFT,
        ST_HOLD
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/tkmh_in_if.sv =====
// ----------------------------------------------------------------------------
// tkmh_in_if
// Candidate channel: one transaction carries a point index and its score.
// ----------------------------------------------------------------------------
`default_nettype none

interface tkmh_in_if;
    logic             valid;
    logic             ready;
    tkmh_pkg::point_t point_index;
    tkmh_pkg::score_t score;

    modport source (output valid, output point_index, output score, input ready);
    modport sink   (input valid, input point_index, input score, output ready);
endinterface

`default_nettype wire

// ===== rtl/tkmh_out_if.sv =====
// ----------------------------------------------------------------------------
// tkmh_out_if
// Result channel: root entry of the heap and the insert count.
// ----------------------------------------------------------------------------
`default_nettype none

interface tkmh_out_if;
    logic                         valid;
    logic                         ready;
    tkmh_pkg::point_t             min_point;
    tkmh_pkg::score_t             min_score;
    logic [tkmh_pkg::ELEM_W-1:0]  element_count;

    modport source (output valid, output min_point, output min_score,
                    output element_count, input ready);
    modport sink   (input valid, input min_point, input min_score,
                    input element_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/tkmh_cmp.sv =====
// ----------------------------------------------------------------------------
// tkmh_cmp
// Shared compare unit: picks the smaller child (right on a tie) and decides
// whether the sinking entry moves below it.
// ----------------------------------------------------------------------------
`default_nettype none

module tkmh_cmp (
    input  tkmh_pkg::score_t   carry_score,
    input  tkmh_pkg::score_t   left_score,
    input  tkmh_pkg::score_t   right_score,
    input  logic               has_left,
    input  logic               has_right,
    output tkmh_pkg::cmp_res_t res
);

    tkmh_pkg::score_t child_score;

    // child choice, right wins a tie
    always_comb
    begin
        res.pick_right = has_right && (right_score <= left_score);
        child_score    = res.pick_right ? right_score : left_score;
        res.swap       = has_left && (carry_score > child_score);
    end

endmodule

`default_nettype wire

// ===== rtl/top_k_min_heap_replace_root_top.sv =====
// ----------------------------------------------------------------------------
// top_k_min_heap_replace_root_top
// Fixed binary min-heap: each insert replaces the root and sifts it down.
// ----------------------------------------------------------------------------
// Each candidate transaction overwrites the heap root and sinks it one level
// per clock through a single compare unit, reading both children from a
// two-read-port heap memory whose data is registered. After the accept cycle
// the entry sinks until no child holds a smaller score, and the result is
// registered once the output register is free; the block is ready again in
// the cycle the result appears and takes no new candidate before then. A
// held result does not block the next candidate; only a second finished
// result waits until the first is taken. Entries that were never written
// read as index 0 and score 0 through per-entry valid bits cleared by reset.
// element_count saturates at HEAP_SIZE.
// ----------------------------------------------------------------------------
`default_nettype none

module top_k_min_heap_replace_root_top (
    input  logic              clk,
    input  logic              rst_n,
    tkmh_in_if.sink           in_ch,
    tkmh_out_if.source        out_ch
);

    localparam int IDX_W = tkmh_pkg::IDX_W;
    localparam int CNT_W = tkmh_pkg::CNT_W;

    // heap storage
    tkmh_pkg::entry_t                   heap_mem [tkmh_pkg::HEAP_SIZE];
    logic [tkmh_pkg::HEAP_SIZE-1:0]     valid_reg;
    tkmh_pkg::entry_t                   left_rd_reg;
    tkmh_pkg::entry_t                   right_rd_reg;
    logic                               left_vld_reg;
    logic                               right_vld_reg;

    // sequencer state
    tkmh_pkg::state_t                   state_reg, state_next;
    logic [IDX_W-1:0]                   pos_reg, pos_next;
    tkmh_pkg::entry_t                   carry_reg, carry_next;
    tkmh_pkg::entry_t                   root_reg;
    logic [CNT_W-1:0]                   count_reg;

    // output register
    logic                               out_valid_reg;
    tkmh_pkg::entry_t                   out_ent_reg;
    logic [CNT_W-1:0]                   out_cnt_reg;

    // datapath signals
    logic                               in_fire;
    logic                               out_free;
    logic [IDX_W+1:0]                   left_full;
    logic [IDX_W+1:0]                   right_full;
    logic                               has_left;
    logic                               has_right;
    tkmh_pkg::entry_t                   left_ent;
    tkmh_pkg::entry_t                   right_ent;
    tkmh_pkg::entry_t                   child_ent;
    logic [IDX_W-1:0]                   pick_idx;
    logic [IDX_W:0]                     pick_left;
    tkmh_pkg::cmp_res_t                 cmp_res;
    logic                               wr_en;
    logic [IDX_W-1:0]                   wr_addr;
    tkmh_pkg::entry_t                   wr_data;
    logic [IDX_W-1:0]                   rd_left;
    logic [IDX_W-1:0]                   rd_right;
    tkmh_pkg::entry_t                   root_now;
    logic                               load_out;

    assign in_ch.ready = (state_reg == tkmh_pkg::ST_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;

    // children of the current position
    assign left_full  = {1'b0, pos_reg, 1'b1};
    assign right_full = left_full + (IDX_W+2)'(1);
    assign has_left   = (left_full  <= (IDX_W+2)'(tkmh_pkg::LAST));
    assign has_right  = (right_full <= (IDX_W+2)'(tkmh_pkg::LAST));
    assign left_ent   = left_vld_reg  ? left_rd_reg  : '0;
    assign right_ent  = right_vld_reg ? right_rd_reg : '0;

    tkmh_cmp u_cmp (
        .carry_score (carry_reg.score),
        .left_score  (left_ent.score),
        .right_score (right_ent.score),
        .has_left    (has_left),
        .has_right   (has_right),
        .res         (cmp_res)
    );

    assign child_ent = cmp_res.pick_right ? right_ent : left_ent;
    assign pick_idx  = cmp_res.pick_right ? right_full[IDX_W-1:0] : left_full[IDX_W-1:0];
    assign pick_left = {pick_idx, 1'b1};
    assign root_now  = (wr_en && (wr_addr == '0)) ? wr_data : root_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tkmh_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = tkmh_pkg::ST_SIFT;
                end
            end
            tkmh_pkg::ST_SIFT:
            begin
                if (!cmp_res.swap)
                begin
                    state_next = out_free ? tkmh_pkg::ST_IDLE : tkmh_pkg::ST_HOLD;
                end
            end
            tkmh_pkg::ST_HOLD:
            begin
                if (out_free)
                begin
                    state_next = tkmh_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tkmh_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs: memory ports, position and sinking entry
    always_comb
    begin
        wr_en      = 1'b0;
        wr_addr    = pos_reg;
        wr_data    = carry_reg;
        rd_left    = IDX_W'(1);
        rd_right   = IDX_W'(2);
        pos_next   = pos_reg;
        carry_next = carry_reg;
        load_out   = 1'b0;
        case (state_reg)
            tkmh_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    carry_next = '{point: in_ch.point_index, score: in_ch.score};
                    pos_next   = '0;
                end
            end
            tkmh_pkg::ST_SIFT:
            begin
                wr_en = 1'b1;
                if (cmp_res.swap)
                begin
                    wr_data  = child_ent;
                    pos_next = pick_idx;
                    rd_left  = IDX_W'(pick_left);
                    rd_right = IDX_W'(pick_left + (IDX_W+1)'(1));
                end
                else
                begin
                    load_out = out_free;
                end
            end
            tkmh_pkg::ST_HOLD:
            begin
                load_out = out_free;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // heap memory, two registered reads and one write
    always_ff @(posedge clk)
    begin
        left_rd_reg  <= heap_mem[rd_left];
        right_rd_reg <= heap_mem[rd_right];
        if (wr_en)
        begin
            heap_mem[wr_addr] <= wr_data;
        end
    end

    // per-entry valid bits, unwritten entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            left_vld_reg  <= 1'b0;
            right_vld_reg <= 1'b0;
        end
        else
        begin
            left_vld_reg  <= valid_reg[rd_left];
            right_vld_reg <= valid_reg[rd_right];
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tkmh_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire && (count_reg < CNT_W'(tkmh_pkg::HEAP_SIZE)))
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        carry_reg <= carry_next;
        if (wr_en && (wr_addr == '0))
        begin
            root_reg <= wr_data;
        end
        if (load_out)
        begin
            out_ent_reg <= root_now;
            out_cnt_reg <= count_reg;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.min_point     = out_ent_reg.point;
    assign out_ch.min_score     = out_ent_reg.score;
    assign out_ch.element_count = tkmh_pkg::ELEM_W'(out_cnt_reg);

endmodule

`default_nettype wire

// ===== rtl/tkmh_chk.sv =====
// ----------------------------------------------------------------------------
// tkmh_chk
// Port-level checks for the heap block, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module tkmh_chk (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [31:0]                 min_point,
    input  logic [31:0]                 min_score,
    input  logic [tkmh_pkg::ELEM_W-1:0] element_count
);

    // the sift keeps the block busy in the cycle after an accepted transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("candidate taken in the cycle after an accept");

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(min_point) && $stable(min_score)
             && $stable(element_count)))
        else $error("result changed while stalled");

    // a new result appears only as the sequencer returns to idle
    a_out_with_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result raised while the heap is still busy");

    // every result follows at least one insert and respects saturation
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((element_count != '0)
                       && (int'(element_count) <= tkmh_pkg::HEAP_SIZE)))
        else $error("element count out of range");

endmodule

bind top_k_min_heap_replace_root_top tkmh_chk u_tkmh_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .min_point     (out_ch.min_point),
    .min_score     (out_ch.min_score),
    .element_count (out_ch.element_count)
);

`default_nettype wire
